@@ hdl/hrf_pkg.sv @@
// Package for the request framer: key status codes, key text and code values.
// No dependencies.
package hrf_pkg;

	localparam int CONN_COUNT_DEFAULT  = 64;
	localparam int LENGTH_BITS_DEFAULT = 32;
	localparam int KEY_LEN             = 16;
	localparam int TERM_LEN            = 4;
	localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_DROP = 1'b1;

	typedef enum logic [1:0] {
		KS_SEARCH  = 2'd0,
		KS_DIGITS  = 2'd1,
		KS_DONE    = 2'd2,
		KS_CLAMPED = 2'd3
	} key_status_t;

	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_LF = 8'h0a;

	function automatic logic [7:0] key_char(input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0: ch = "C";
			4'd1: ch = "o";
			4'd2: ch = "n";
			4'd3: ch = "t";
			4'd4: ch = "e";
			4'd5: ch = "n";
			4'd6: ch = "t";
			4'd7: ch = "-";
			4'd8: ch = "L";
			4'd9: ch = "e";
			4'd10: ch = "n";
			4'd11: ch = "g";
			4'd12: ch = "t";
			4'd13: ch = "h";
			4'd14: ch = ":";
			default: ch = " ";
		endcase
		return ch;
	endfunction

endpackage

@@ hdl/hrf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                            clk,
	input  logic                                            we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
	input  logic [WIDTH-1:0]                                wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
	output logic [WIDTH-1:0]                                rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/hrf_front.sv @@
// Front part: accepts requests, drops out-of-range connections and hands them on a short queue.
// Depends on hrf_pkg.
module hrf_front #(
	parameter int CONN_COUNT = hrf_pkg::CONN_COUNT_DEFAULT,
	parameter int CW         = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic          op,
	input  logic [5:0]    conn,
	input  logic [7:0]    data,
	output logic          q_valid,
	input  logic          q_take,
	output logic          q_op,
	output logic [CW-1:0] q_conn,
	output logic [7:0]    q_data
);
	import hrf_pkg::*;

	localparam int QD = 4;

	logic          op_q   [QD];
	logic [CW-1:0] conn_q [QD];
	logic [7:0]    data_q [QD];
	logic [1:0]    wp_q, rp_q;
	logic [2:0]    cnt_q;
	logic          acc, keep;

	assign full    = (cnt_q == 3'(QD));
	assign acc     = push && !full;
	assign keep    = acc && ({26'd0, conn} < 32'(CONN_COUNT));
	assign q_valid = (cnt_q != 3'd0);
	assign q_op    = op_q[rp_q];
	assign q_conn  = conn_q[rp_q];
	assign q_data  = data_q[rp_q];

	always_ff @(posedge clk) begin
		if (keep) begin
			op_q[wp_q]   <= op;
			conn_q[wp_q] <= CW'(conn);
			data_q[wp_q] <= data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (keep) wp_q <= wp_q + 2'd1;
			if (q_take) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(keep) - 3'(q_take);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'(QD))
		else $error("front queue count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) q_take |-> q_valid)
		else $error("front queue read while empty");

endmodule

@@ hdl/hrf_back.sv @@
// Back part: per-connection parse state in a RAM, read when a request is taken and updated in the cycle after,
// with a bypass for back-to-back requests on one connection, and an output queue.
// Depends on hrf_pkg and hrf_ram.
module hrf_back #(
	parameter int CONN_COUNT  = hrf_pkg::CONN_COUNT_DEFAULT,
	parameter int LENGTH_BITS = hrf_pkg::LENGTH_BITS_DEFAULT,
	parameter int CW          = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [31:0]   max_len,
	input  logic          q_valid,
	output logic          q_take,
	input  logic          q_op,
	input  logic [CW-1:0] q_conn,
	input  logic [7:0]    q_data,
	output logic          empty,
	input  logic          pop,
	output logic [5:0]    conn_out,
	output logic [7:0]    data_out,
	output logic          in_body,
	output logic          last,
	output logic [31:0]   request_length,
	output logic          length_clamped
);
	import hrf_pkg::*;

	localparam int LB = LENGTH_BITS;
	localparam logic [LB-1:0] LEN_MAX = '1;
	localparam int OD = 4;
	localparam int SW = 11 + 2 * LB;

	typedef struct packed {
		logic          phase;
		logic [2:0]    term;
		logic [4:0]    key;
		key_status_t   ks;
		logic [LB-1:0] blen;
		logic [LB-1:0] bcnt;
	} conn_state_t;

	logic          s1_valid_q, s1_op_q;
	logic [CW-1:0] s1_conn_q;
	logic [7:0]    s1_data_q;
	logic          byp_valid_q;
	logic [CW-1:0] byp_conn_q;
	conn_state_t   byp_state_q;
	logic          clr_busy_q;
	logic [CW-1:0] clr_idx_q;

	logic          ram_we;
	logic [CW-1:0] ram_waddr;
	logic [SW-1:0] ram_wdata, ram_rdata;
	conn_state_t   cur, wr_state;

	logic [5:0]  oc_q [OD];
	logic [7:0]  od_q [OD];
	logic        ob_q [OD], ol_q [OD], ok_q [OD];
	logic [31:0] orl_q [OD];
	logic [1:0]  owp_q, orp_q;
	logic [2:0]  ocnt_q;

	logic          ph, n_ph, body, lst, done_t;
	logic [2:0]    t, n_t;
	logic [4:0]    k, n_k;
	key_status_t   ks, n_ks;
	logic [LB-1:0] bl, n_bl, bc, lim, dig;
	logic [LB+3:0] prod;
	logic [7:0]    b;
	logic          s1_data, out_pop, room;

	assign b       = s1_data_q;
	assign s1_data = s1_valid_q && (s1_op_q == OP_DATA);
	assign out_pop = pop && !empty;
	assign room    = (ocnt_q + 3'(s1_data)) < 3'(OD);
	assign q_take  = q_valid && !clr_busy_q && (q_op == OP_DROP || room);
	assign ram_we    = clr_busy_q || s1_valid_q;
	assign ram_waddr = clr_busy_q ? clr_idx_q : s1_conn_q;

	hrf_ram #(.WIDTH(SW), .DEPTH(CONN_COUNT)) u_state (
		.clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata), .raddr(q_conn),
		.rdata(ram_rdata)
	);

	always_comb begin
		cur = (byp_valid_q && byp_conn_q == s1_conn_q) ? byp_state_q :
			conn_state_t'(ram_rdata);
		ph  = cur.phase;
		t   = cur.term;
		k   = cur.key;
		ks  = cur.ks;
		bl  = cur.blen;
		bc  = (cur.bcnt != LEN_MAX) ? cur.bcnt + 1'b1 : cur.bcnt;
		lim = (LB >= 32) ? LB'(max_len) : ((max_len > 32'(LEN_MAX)) ? LEN_MAX : LB'(max_len));
		dig = LB'(b - "0");
		prod = {4'd0, bl} * 4'd10 + {4'd0, dig};
		n_ph = ph; n_t = t; n_k = k; n_ks = ks; n_bl = bl;
		body = 1'b0; lst = 1'b0; done_t = 1'b0;
		if (ph) begin
			body = 1'b1;
			if (bl != '0) n_bl = bl - 1'b1;
			if (n_bl == '0) lst = 1'b1;
		end else begin
			if (ks == KS_DIGITS) begin
				if (b < "0" || b > "9") begin
					n_ks = KS_DONE;
				end else if (prod[LB+3:LB] != 4'd0 || prod[LB-1:0] > lim) begin
					n_bl = lim;
					n_ks = KS_CLAMPED;
				end else begin
					n_bl = prod[LB-1:0];
				end
			end else if (ks == KS_SEARCH) begin
				if (k < 5'(KEY_LEN) && b == key_char(k[3:0])) n_k = k + 5'd1;
				else n_k = (b == key_char(4'd0)) ? 5'd1 : 5'd0;
				if (n_k == 5'(KEY_LEN)) n_ks = KS_DIGITS;
			end
			if (b == ((t[0]) ? CH_LF : CH_CR)) n_t = t + 3'd1;
			else n_t = (b == CH_CR) ? 3'd1 : 3'd0;
			if (n_t >= 3'(TERM_LEN)) begin
				n_t = 3'd0;
				done_t = 1'b1;
			end
			if (done_t) begin
				if (n_ks == KS_DIGITS) n_ks = KS_DONE;
				if (n_bl == '0) lst = 1'b1;
				else n_ph = 1'b1;
			end
		end
		wr_state = '0;
		if (s1_op_q == OP_DATA && !lst) begin
			wr_state.phase = n_ph;
			wr_state.term  = n_t;
			wr_state.key   = n_k;
			wr_state.ks    = n_ks;
			wr_state.blen  = n_bl;
			wr_state.bcnt  = bc;
		end
		if (clr_busy_q) ram_wdata = '0;
		else ram_wdata = wr_state;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s1_op_q     <= OP_DATA;
			s1_conn_q   <= '0;
			s1_data_q   <= '0;
			byp_valid_q <= 1'b0;
			byp_conn_q  <= '0;
			byp_state_q <= '0;
			clr_busy_q  <= 1'b1;
			clr_idx_q   <= '0;
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			s1_valid_q  <= q_take;
			s1_op_q     <= q_op;
			s1_conn_q   <= q_conn;
			s1_data_q   <= q_data;
			byp_valid_q <= s1_valid_q;
			byp_conn_q  <= s1_conn_q;
			byp_state_q <= wr_state;
			if (clr_busy_q) begin
				if (clr_idx_q == CW'(CONN_COUNT - 1)) clr_busy_q <= 1'b0;
				else clr_idx_q <= clr_idx_q + CW'(1);
			end
			if (s1_data) owp_q <= owp_q + 2'd1;
			if (out_pop) orp_q <= orp_q + 2'd1;
			ocnt_q <= ocnt_q + 3'(s1_data) - 3'(out_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_data) begin
			oc_q[owp_q]  <= 6'(s1_conn_q);
			od_q[owp_q]  <= b;
			ob_q[owp_q]  <= body;
			ol_q[owp_q]  <= lst;
			ok_q[owp_q]  <= (n_ks == KS_CLAMPED);
			orl_q[owp_q] <= !lst ? 32'd0 :
				((LB > 32 && (bc >> 32) != '0) ? 32'hffff_ffff : 32'(bc));
		end
	end

	assign empty          = (ocnt_q == 3'd0);
	assign conn_out       = oc_q[orp_q];
	assign data_out       = od_q[orp_q];
	assign in_body        = ob_q[orp_q];
	assign last           = ol_q[orp_q];
	assign request_length = orl_q[orp_q];
	assign length_clamped = ok_q[orp_q];

	assert property (@(posedge clk) disable iff (!arst_n) ocnt_q <= 3'(OD))
		else $error("output queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) (!empty && !last) |-> request_length == 0)
		else $error("length on non-last result");
	assert property (@(posedge clk) disable iff (!arst_n) s1_data |-> ocnt_q < 3'(OD))
		else $error("result written with output queue full");
	assert property (@(posedge clk) disable iff (!arst_n) clr_busy_q |-> !q_take)
		else $error("request taken during state clearing");

endmodule

@@ hdl/http_request_framer.sv @@
// HTTP request framer top level: configuration register, front queue and back parser.
// Depends on hrf_pkg, hrf_front and hrf_back.
//
// Requests enter as (op, conn, data) with push/full and leave in order on the result
// ports with empty/pop. Each data byte gives one result tagged in_body; the byte that
// completes a request has last set and the total request length. A drop clears one
// connection's parse state and gives no result, as do connections at or above CONN_COUNT.
// The block takes one request per cycle while full is low; a byte passes through the
// front queue, then a state read cycle and an update cycle that writes the output queue.
// The rate is set by the per-connection state RAM, which is read when a request is taken
// and written in the cycle after, with a bypass so that back-to-back bytes on one
// connection see the latest state. When the receiver stalls, the four-entry output queue
// fills, then the four-entry front queue, and full rises. Reset clears both queues and
// sets max_body_length to 1048576; it then clears the state RAM entry by entry, and
// requests are held in the front queue until that is done. max_body_length may be
// rewritten through cfg_we/cfg_data while idle.
module http_request_framer #(
	parameter int CONN_COUNT  = hrf_pkg::CONN_COUNT_DEFAULT,
	parameter int LENGTH_BITS = hrf_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        op,
	input  logic [5:0]  conn,
	input  logic [7:0]  data,
	output logic        empty,
	input  logic        pop,
	output logic [5:0]  conn_out,
	output logic [7:0]  data_out,
	output logic        in_body,
	output logic        last,
	output logic [31:0] request_length,
	output logic        length_clamped
);
	import hrf_pkg::*;

	localparam int CW = (CONN_COUNT > 1) ? $clog2(CONN_COUNT) : 1;

	logic [31:0]   max_q;
	logic          q_valid, q_take, q_op;
	logic [CW-1:0] q_conn;
	logic [7:0]    q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_BODY_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_data;
		end
	end

	hrf_front #(.CONN_COUNT(CONN_COUNT), .CW(CW)) u_front (
		.clk, .arst_n, .push, .full, .op, .conn, .data,
		.q_valid, .q_take, .q_op, .q_conn, .q_data
	);

	hrf_back #(.CONN_COUNT(CONN_COUNT), .LENGTH_BITS(LENGTH_BITS), .CW(CW)) u_back (
		.clk, .arst_n, .max_len(max_q), .q_valid, .q_take, .q_op, .q_conn, .q_data,
		.empty, .pop, .conn_out, .data_out, .in_body, .last, .request_length,
		.length_clamped
	);

endmodule

@@ tb/testbench.sv @@
// Testbench for http_request_framer: random and directed HTTP-like byte streams on many
// connections, with a behavioral predictor and an in-order result checker.
// Depends on hrf_pkg and the http_request_framer RTL.
`timescale 1ns / 100ps

module testbench;
	import hrf_pkg::*;

	typedef struct packed {
		logic [5:0]  conn;
		logic [7:0]  data;
		logic        in_body;
		logic        last;
		logic [31:0] length;
		logic        clamped;
	} frame_t;

	typedef struct {
		logic        body_phase;
		int unsigned term_match;
		int unsigned key_pos;
		key_status_t key_state;
		logic [31:0] body_left;
		logic [31:0] count;
	} conn_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_data = '0;
	logic push = 1'b0;
	logic op = OP_DATA;
	logic [5:0] conn = '0;
	logic [7:0] data = '0;
	logic pop = 1'b0;
	logic full, empty, in_body, last, length_clamped;
	logic [5:0] conn_out;
	logic [7:0] data_out;
	logic [31:0] request_length;

	conn_state_t parse_state [64];
	logic [31:0] body_limit;
	frame_t pending_frames [$];
	int errors = 0;
	int requests_sent = 0;
	int frames_checked = 0;
	int requests_completed = 0;
	int cycle_count = 0;

	http_request_framer dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.push(push), .full(full), .op(op), .conn(conn), .data(data),
		.empty(empty), .pop(pop), .conn_out(conn_out), .data_out(data_out),
		.in_body(in_body), .last(last), .request_length(request_length),
		.length_clamped(length_clamped)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [7:0] key_byte(int unsigned i);
		string k;
		k = "Content-Length: ";
		return k[i];
	endfunction

	function automatic void clear_conn(logic [5:0] c);
		parse_state[c].body_phase = 1'b0;
		parse_state[c].term_match = 0;
		parse_state[c].key_pos = 0;
		parse_state[c].key_state = KS_SEARCH;
		parse_state[c].body_left = '0;
		parse_state[c].count = '0;
	endfunction

	function automatic void predict_frame(logic o, logic [5:0] c, logic [7:0] b);
		frame_t f;
		conn_state_t s;
		logic [35:0] wide;
		int unsigned t;
		s = parse_state[c];
		if (o == OP_DROP) begin
			clear_conn(c);
			return;
		end
		f = '0;
		f.conn = c;
		f.data = b;
		if (s.count != 32'hffffffff) s.count++;
		if (s.body_phase) begin
			f.in_body = 1'b1;
			if (s.body_left != 0) s.body_left--;
			if (s.body_left == 0) f.last = 1'b1;
		end else begin
			if (s.key_state == KS_DIGITS) begin
				if (b < "0" || b > "9") begin
					s.key_state = KS_DONE;
				end else begin
					wide = {4'd0, s.body_left} * 36'd10 + {28'd0, b - 8'h30};
					if (wide > {4'd0, body_limit}) begin
						s.body_left = body_limit;
						s.key_state = KS_CLAMPED;
					end else begin
						s.body_left = wide[31:0];
					end
				end
			end else if (s.key_state == KS_SEARCH) begin
				if (s.key_pos < KEY_LEN && b == key_byte(s.key_pos))
					s.key_pos++;
				else
					s.key_pos = (b == key_byte(0)) ? 1 : 0;
				if (s.key_pos == KEY_LEN) s.key_state = KS_DIGITS;
			end
			t = s.term_match;
			if (b == ((t & 1) ? CH_LF : CH_CR)) t++;
			else t = (b == CH_CR) ? 1 : 0;
			if (t >= TERM_LEN) begin
				s.term_match = 0;
				if (s.key_state == KS_DIGITS) s.key_state = KS_DONE;
				if (s.body_left == 0) f.last = 1'b1;
				else s.body_phase = 1'b1;
			end else begin
				s.term_match = t;
			end
		end
		f.clamped = (s.key_state == KS_CLAMPED);
		if (f.last) f.length = s.count;
		parse_state[c] = s;
		if (f.last) clear_conn(c);
		pending_frames.push_back(f);
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 2000000) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	int stall_phase = 0;
	always @(posedge clk) begin
		stall_phase <= (stall_phase + 1) % 23;
		if (stall_phase < 5) pop <= 1'b1;
		else if (stall_phase < 12) pop <= ($urandom_range(0, 2) != 0);
		else pop <= ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk) begin
		frame_t e;
		if (arst_n && pop && !empty) begin
			if (pending_frames.size() == 0) begin
				$error("unexpected result conn_out=%0d data_out=%0h", conn_out, data_out);
				errors++;
			end else begin
				e = pending_frames.pop_front();
				frames_checked++;
				if (e.last) requests_completed++;
				if (conn_out !== e.conn) begin
					$error("conn_out expected %0d actual %0d", e.conn, conn_out);
					errors++;
				end
				if (data_out !== e.data) begin
					$error("data_out expected %0h actual %0h", e.data, data_out);
					errors++;
				end
				if (in_body !== e.in_body) begin
					$error("in_body expected %0b actual %0b", e.in_body, in_body);
					errors++;
				end
				if (last !== e.last) begin
					$error("last expected %0b actual %0b", e.last, last);
					errors++;
				end
				if (request_length !== e.length) begin
					$error("request_length expected %0d actual %0d", e.length, request_length);
					errors++;
				end
				if (length_clamped !== e.clamped) begin
					$error("length_clamped expected %0b actual %0b", e.clamped,
						length_clamped);
					errors++;
				end
			end
		end
	end

	int gap_left = 0;
	int burst_left = 0;

	task automatic send_request(logic o, logic [5:0] c, logic [7:0] b);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
		end
		burst_left--;
		if (gap_left > 0) begin
			push <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		push <= 1'b1;
		op <= o;
		conn <= c;
		data <= b;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_frame(o, c, b);
		requests_sent++;
	endtask

	task automatic hold_push_low();
		push <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		hold_push_low();
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_limit(logic [31:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		body_limit = v;
		@(posedge clk);
	endtask

	task automatic send_text(logic [5:0] c, string s);
		for (int i = 0; i < s.len(); i++) send_request(OP_DATA, c, s[i]);
	endtask

	task automatic send_framed(logic [5:0] c, int unsigned len_val, bit with_key);
		string s;
		s = "GET / HTTP/1.1\r\n";
		if (with_key) s = {s, $sformatf("Content-Length: %0d\r\n", len_val)};
		s = {s, "\r\n"};
		send_text(c, s);
		if (with_key) begin
			for (int i = 0; i < (len_val < body_limit ? len_val : body_limit); i++)
				send_request(OP_DATA, c, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic test_directed();
		send_request(OP_DATA, 6'd63, 8'hff);
		send_request(OP_DATA, 6'd0, 8'h00);
		send_request(OP_DROP, 6'd0, 8'h55);
		send_request(OP_DROP, 6'd63, 8'haa);
		send_text(6'd1, "\r\n\r\n");
		send_text(6'd2, "Content-Length: \r\n\r\n");
		send_text(6'd3, "Content-Length: 2x\r\n\r\nab");
	endtask

	task automatic test_repeated_key();
		send_text(6'd4, "Content-Length: 1\r\nContent-Length: 3\r\n\r\nZ");
		send_request(OP_DATA, 6'd5, "C");
		send_request(OP_DROP, 6'd5, 8'h00);
		send_text(6'd5, "\r\r\n\r\n");
	endtask

	task automatic test_clamp_limits();
		write_limit(32'd0);
		send_text(6'd6, "Content-Length: 7\r\n\r\n");
		write_limit(32'd3);
		send_framed(6'd7, 99999, 1'b1);
		write_limit(32'hffffffff);
		send_text(6'd8, "Content-Length: 99999999999\r\n\r\n");
		send_request(OP_DROP, 6'd8, 8'h00);
		write_limit(MAX_BODY_RESET);
	endtask

	task automatic test_random_traffic(int total);
		int sent;
		logic [5:0] c;
		sent = 0;
		while (sent < total) begin
			c = 6'($urandom_range(0, 63));
			case ($urandom_range(0, 9))
				0: begin
					send_request(1'($urandom_range(0, 1)), c, 8'($urandom_range(0, 255)));
					sent++;
				end
				1: begin
					send_text(c, "Content-Length: 12");
					send_request(OP_DROP, c, 8'($urandom_range(0, 255)));
					sent += 19;
				end
				2: begin
					send_framed(c, 0, 1'b0);
					sent += 18;
				end
				default: begin
					send_framed(c, $urandom_range(0, 12), 1'b1);
					sent += 40;
				end
			endcase
			if ($urandom_range(0, 60) == 0) drain();
		end
	endtask

	initial begin
		body_limit = MAX_BODY_RESET;
		for (int i = 0; i < 64; i++) clear_conn(6'(i));
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_repeated_key();
		test_clamp_limits();
		write_limit(32'd5);
		test_random_traffic(800);
		write_limit(MAX_BODY_RESET);
		test_random_traffic(1200);
		drain();
		$display("Sent %0d requests, checked %0d results, %0d framed requests completed.",
			requests_sent, frames_checked, requests_completed);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
